[rtl/hrp_pkg.sv]
// Package with the widths, codes and constants shared by the H.264 RTP packetizer files.
package hrp_pkg;

   localparam int DATA_W = 8;
   localparam int LEN_W = 16;
   localparam int SEQ_W = 16;
   localparam int TS_W = 32;
   localparam int PT_W = 7;
   localparam int SSRC_W = 32;
   localparam int MAXPAY_W = 11;
   localparam int TSSTEP_W = 17;
   localparam int FU_TYPE_W = 5;
   localparam int POS_W = 4;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_INDEX_W-1:0] REG_PAYLOAD_TYPE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_SSRC = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_MAX_PAYLOAD = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_TIMESTAMP_STEP = 2'd3;

   localparam logic [PT_W-1:0] PAYLOAD_TYPE_RESET = 7'd96;
   localparam logic [SSRC_W-1:0] SSRC_RESET = 32'd0;
   localparam logic [MAXPAY_W-1:0] MAX_PAYLOAD_RESET = 11'd1400;
   localparam logic [TSSTEP_W-1:0] TIMESTAMP_STEP_RESET = 17'd3600;

   localparam int PAYLOAD_LIMIT_DEFAULT = 1400;
   localparam int MIN_PAYLOAD = 2;
   localparam int HEADER_BYTES = 12;

   localparam logic [DATA_W-1:0] RTP_FIRST_BYTE = 8'h80;
   localparam logic [DATA_W-1:0] FU_A_TYPE = 8'd28;
   localparam logic [DATA_W-1:0] NRI_MASK = 8'hE0;
   localparam logic [DATA_W-1:0] TYPE_MASK = 8'h1F;
   localparam logic [DATA_W-1:0] FU_START_BIT = 8'h80;
   localparam logic [DATA_W-1:0] FU_END_BIT = 8'h40;

   localparam logic [POS_W-1:0] POS_FIRST = 4'd0;
   localparam logic [POS_W-1:0] POS_LAST_HEADER = 4'd11;
   localparam logic [POS_W-1:0] POS_FU_INDICATOR = 4'd12;
   localparam logic [POS_W-1:0] POS_FU_HEADER = 4'd13;
   localparam logic [POS_W-1:0] POS_DATA = 4'd14;

endpackage

[rtl/hrp_req_if.sv]
// Interface for the NAL byte input channel.
interface hrp_req_if;
   logic                          valid;
   logic                          ready;
   logic [hrp_pkg::DATA_W-1:0]    data_byte;
   logic [hrp_pkg::LEN_W-1:0]     nal_length;

   modport source (output valid, output data_byte, output nal_length, input ready);
   modport sink (input valid, input data_byte, input nal_length, output ready);
endinterface

[rtl/hrp_rsp_if.sv]
// Interface for the RTP packet byte output channel.
interface hrp_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [hrp_pkg::DATA_W-1:0]    out_byte;
   logic                          packet_end;
   logic                          run_last;

   modport source (output valid, output out_byte, output packet_end, output run_last,
                   input ready);
   modport sink (input valid, input out_byte, input packet_end, input run_last,
                 output ready);
endinterface

[rtl/h264_rtp_packetizer_top.sv]
// Top level of the H.264 RTP packetizer with single NAL unit and FU-A packetization.
//
// The req channel carries NAL unit bytes, header byte first, each with the NAL
// length, which is sampled only on the first byte of a NAL. The rsp channel
// carries RTP packet bytes with a packet end flag and a flag on the last byte
// caused by each input byte. The user must write registers through the csr port
// only while the block is idle; the block itself does not enforce it.
// A byte that opens a packet yields a 12-byte RTP header, for FU-A also the FU
// indicator and FU header, and then the data byte. Other payload bytes yield
// only the data byte, so the input streams at one byte per cycle inside a packet
// while the receiver does not stall. The FU-A NAL header byte yields no output bytes.
// A transfer is kept in a descriptor register while a position counter walks its
// bytes into the output register; the first byte of a transfer is held in the
// descriptor register and reaches the rsp port through the output register.
// Reset clears the sequence number, timestamp, NAL progress and both output
// stages and restores the register defaults. When the receiver stalls, the
// output register holds its byte and the input is taken again only once the
// descriptor has been drained.
module h264_rtp_packetizer_top #(
   parameter int PAYLOAD_LIMIT = hrp_pkg::PAYLOAD_LIMIT_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   hrp_req_if.sink                             req_if,
   hrp_rsp_if.source                           rsp_if,
   input  logic                                csr_write_enable,
   input  logic [hrp_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [hrp_pkg::CSR_DATA_W-1:0]      csr_write_data
);

   localparam int FILL_W = $clog2(PAYLOAD_LIMIT + 1);
   localparam int LEN_W = hrp_pkg::LEN_W;
   localparam int DATA_W = hrp_pkg::DATA_W;
   localparam int HDR_W = hrp_pkg::HEADER_BYTES * DATA_W;

   logic [hrp_pkg::PT_W-1:0]        payload_type_ff;
   logic [hrp_pkg::SSRC_W-1:0]      ssrc_ff;
   logic [hrp_pkg::MAXPAY_W-1:0]    max_payload_ff;
   logic [hrp_pkg::TSSTEP_W-1:0]    timestamp_step_ff;

   logic [hrp_pkg::SEQ_W-1:0]       seq_ff, seq_in;
   logic [hrp_pkg::TS_W-1:0]        ts_ff, ts_in;
   logic [LEN_W-1:0]                left_ff, left_in;
   logic [FILL_W-1:0]               fill_ff, fill_in;
   logic                            frag_ff, frag_in;
   logic [DATA_W-1:0]               fu_ind_ff, fu_ind_in;
   logic [hrp_pkg::FU_TYPE_W-1:0]   fu_type_ff, fu_type_in;
   logic                            fu_start_ff, fu_start_in;

   logic                            desc_valid_ff;
   logic [hrp_pkg::POS_W-1:0]       pos_ff, pos_in;
   logic                            desc_fu_ff;
   logic [hrp_pkg::SEQ_W-1:0]       desc_seq_ff;
   logic [hrp_pkg::TS_W-1:0]        desc_ts_ff;
   logic [DATA_W-1:0]               desc_fh_ff, desc_ind_ff, desc_data_ff;
   logic                            desc_end_ff;

   logic                            out_valid_ff;
   logic [DATA_W-1:0]               out_byte_ff;
   logic                            out_end_ff;
   logic                            out_last_ff;

   logic [LEN_W-1:0]                eff;
   logic [LEN_W-1:0]                len_eff;
   logic [LEN_W-1:0]                fill_inc;
   logic                            has_out, has_hdr, has_fu, end_flag;
   logic [DATA_W-1:0]               fh;
   logic                            accept, move, desc_done;
   logic [HDR_W-1:0]                hdr_vec;
   logic [DATA_W-1:0]               cur_byte;
   logic                            cur_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         payload_type_ff <= hrp_pkg::PAYLOAD_TYPE_RESET;
         ssrc_ff <= hrp_pkg::SSRC_RESET;
         max_payload_ff <= hrp_pkg::MAX_PAYLOAD_RESET;
         timestamp_step_ff <= hrp_pkg::TIMESTAMP_STEP_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            hrp_pkg::REG_PAYLOAD_TYPE: payload_type_ff <= csr_write_data[hrp_pkg::PT_W-1:0];
            hrp_pkg::REG_SSRC: ssrc_ff <= csr_write_data[hrp_pkg::SSRC_W-1:0];
            hrp_pkg::REG_MAX_PAYLOAD: max_payload_ff <= csr_write_data[hrp_pkg::MAXPAY_W-1:0];
            hrp_pkg::REG_TIMESTAMP_STEP:
               timestamp_step_ff <= csr_write_data[hrp_pkg::TSSTEP_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (LEN_W'(max_payload_ff) < LEN_W'(hrp_pkg::MIN_PAYLOAD)) begin
         eff = LEN_W'(hrp_pkg::MIN_PAYLOAD);
      end else if (LEN_W'(max_payload_ff) > LEN_W'(PAYLOAD_LIMIT)) begin
         eff = LEN_W'(PAYLOAD_LIMIT);
      end else begin
         eff = LEN_W'(max_payload_ff);
      end
   end

   assign pos_in = (pos_ff == hrp_pkg::POS_LAST_HEADER && !desc_fu_ff) ?
                   hrp_pkg::POS_DATA : pos_ff + 1'b1;
   assign desc_done = (pos_ff == hrp_pkg::POS_DATA);
   assign move = desc_valid_ff && (!out_valid_ff || rsp_if.ready);
   assign req_if.ready = !desc_valid_ff || (move && desc_done);
   assign accept = req_if.valid && req_if.ready;

   always_comb begin
      seq_in = seq_ff;
      ts_in = ts_ff;
      left_in = left_ff;
      fill_in = fill_ff;
      frag_in = frag_ff;
      fu_ind_in = fu_ind_ff;
      fu_type_in = fu_type_ff;
      fu_start_in = fu_start_ff;
      has_out = 1'b0;
      has_hdr = 1'b0;
      has_fu = 1'b0;
      end_flag = 1'b0;
      fh = DATA_W'(fu_type_ff);
      fill_inc = LEN_W'(fill_ff) + 1'b1;
      len_eff = (req_if.nal_length == '0) ? LEN_W'(1) : req_if.nal_length;
      if (left_ff == '0) begin
         left_in = len_eff - 1'b1;
         fill_in = '0;
         if (len_eff < eff) begin
            frag_in = 1'b0;
            has_out = 1'b1;
            has_hdr = 1'b1;
            end_flag = (left_in == '0);
         end else begin
            frag_in = 1'b1;
            fu_ind_in = (req_if.data_byte & hrp_pkg::NRI_MASK) | hrp_pkg::FU_A_TYPE;
            fu_type_in = hrp_pkg::FU_TYPE_W'(req_if.data_byte & hrp_pkg::TYPE_MASK);
            fu_start_in = 1'b1;
         end
      end else if (!frag_ff) begin
         left_in = left_ff - 1'b1;
         has_out = 1'b1;
         end_flag = (left_in == '0);
      end else begin
         has_out = 1'b1;
         if (fill_ff == '0) begin
            has_hdr = 1'b1;
            has_fu = 1'b1;
            fu_start_in = 1'b0;
            if (fu_start_ff) begin
               fh = fh | hrp_pkg::FU_START_BIT;
            end
            if (left_ff <= eff) begin
               fh = fh | hrp_pkg::FU_END_BIT;
            end
         end
         left_in = left_ff - 1'b1;
         end_flag = (left_in == '0) || (fill_inc >= eff);
         fill_in = end_flag ? '0 : FILL_W'(fill_inc);
         if (left_in == '0) begin
            frag_in = 1'b0;
         end
      end
      if (has_out && left_in == '0) begin
         ts_in = ts_ff + hrp_pkg::TS_W'(timestamp_step_ff);
      end
      if (has_hdr) begin
         seq_in = seq_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff <= '0;
         ts_ff <= '0;
         left_ff <= '0;
         fill_ff <= '0;
         frag_ff <= 1'b0;
         fu_ind_ff <= '0;
         fu_type_ff <= '0;
         fu_start_ff <= 1'b0;
      end else if (accept) begin
         seq_ff <= seq_in;
         ts_ff <= ts_in;
         left_ff <= left_in;
         fill_ff <= fill_in;
         frag_ff <= frag_in;
         fu_ind_ff <= fu_ind_in;
         fu_type_ff <= fu_type_in;
         fu_start_ff <= fu_start_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         desc_valid_ff <= 1'b0;
         pos_ff <= hrp_pkg::POS_FIRST;
      end else if (accept) begin
         desc_valid_ff <= has_out;
         pos_ff <= has_hdr ? hrp_pkg::POS_FIRST : hrp_pkg::POS_DATA;
      end else if (move) begin
         desc_valid_ff <= !desc_done;
         pos_ff <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         desc_fu_ff <= has_fu;
         desc_seq_ff <= seq_ff;
         desc_ts_ff <= ts_ff;
         desc_fh_ff <= fh;
         desc_ind_ff <= fu_ind_ff;
         desc_data_ff <= req_if.data_byte;
         desc_end_ff <= end_flag;
      end
   end

   assign hdr_vec = {hrp_pkg::RTP_FIRST_BYTE, 1'b0, payload_type_ff, desc_seq_ff,
                     desc_ts_ff, ssrc_ff};

   always_comb begin
      cur_last = 1'b0;
      case (pos_ff)
         hrp_pkg::POS_FU_INDICATOR: cur_byte = desc_ind_ff;
         hrp_pkg::POS_FU_HEADER: cur_byte = desc_fh_ff;
         hrp_pkg::POS_DATA: begin
            cur_byte = desc_data_ff;
            cur_last = 1'b1;
         end
         default: cur_byte = hdr_vec[(hrp_pkg::POS_LAST_HEADER - pos_ff) * DATA_W +: DATA_W];
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (move) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (move) begin
         out_byte_ff <= cur_byte;
         out_end_ff <= cur_last && desc_end_ff;
         out_last_ff <= cur_last;
      end
   end

   assign rsp_if.valid = out_valid_ff;
   assign rsp_if.out_byte = out_byte_ff;
   assign rsp_if.packet_end = out_end_ff;
   assign rsp_if.run_last = out_last_ff;

endmodule

[rtl/hrp_checker.sv]
// Port-level checker for the H.264 RTP packetizer and its bind to the top level.
module hrp_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic [hrp_pkg::DATA_W-1:0]         rsp_out_byte,
   input logic                               rsp_packet_end,
   input logic                               rsp_run_last
);

   logic packet_open_ff;
   logic rsp_transfer;

   assign rsp_transfer = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         packet_open_ff <= 1'b0;
      end else if (rsp_transfer) begin
         packet_open_ff <= !rsp_packet_end;
      end
   end

   // Every packet opens with the RTP version byte.
   a_packet_start: assert property (@(posedge clock) disable iff (reset)
      rsp_transfer && !packet_open_ff |-> rsp_out_byte == hrp_pkg::RTP_FIRST_BYTE)
      else $error("packet does not start with the RTP version byte");

   // The end of a packet is always the last byte caused by its input byte.
   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_packet_end |-> rsp_run_last)
      else $error("packet end without run end");

   a_no_valid_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("output valid right after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte)
      && $stable(rsp_packet_end) && $stable(rsp_run_last))
      else $error("stalled output transfer changed");

endmodule

bind h264_rtp_packetizer_top hrp_checker u_hrp_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_if.valid),
   .rsp_ready      (rsp_if.ready),
   .rsp_out_byte   (rsp_if.out_byte),
   .rsp_packet_end (rsp_if.packet_end),
   .rsp_run_last   (rsp_if.run_last)
);

[dv/h264_rtp_packetizer_top_tb.sv]
`timescale 1ns / 1ps
// Testbench for the H.264 RTP packetizer: NAL byte streams checked per RTP packet byte.
module h264_rtp_packetizer_top_tb;

   localparam int PAYLOAD_LIMIT = hrp_pkg::PAYLOAD_LIMIT_DEFAULT;
   localparam int SETTLE_CYCLES = 24;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_ITEMS = 300;
   localparam int UNPACED_NAL_LENGTH = 60;

   typedef struct packed {
      logic [hrp_pkg::DATA_W-1:0] out_byte;
      logic                       packet_end;
      logic                       run_last;
   } rtp_byte_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            csr_write_enable = 1'b0;
   logic [hrp_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [hrp_pkg::CSR_DATA_W-1:0]  csr_write_data = '0;

   hrp_req_if req_if ();
   hrp_rsp_if rsp_if ();

   h264_rtp_packetizer_top #(
      .PAYLOAD_LIMIT(PAYLOAD_LIMIT)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_if(req_if),
      .rsp_if(rsp_if),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   // Register shadows and packetizer state.
   logic [hrp_pkg::PT_W-1:0]      cfg_payload_type;
   logic [hrp_pkg::SSRC_W-1:0]    cfg_ssrc;
   logic [hrp_pkg::MAXPAY_W-1:0]  cfg_max_payload;
   logic [hrp_pkg::TSSTEP_W-1:0]  cfg_timestamp_step;
   logic [hrp_pkg::SEQ_W-1:0]     rtp_seq;
   logic [hrp_pkg::TS_W-1:0]      rtp_timestamp;
   logic [hrp_pkg::LEN_W-1:0]     nal_left;
   logic [hrp_pkg::MAXPAY_W-1:0]  frag_fill;
   logic                          in_fu_a;
   logic [hrp_pkg::DATA_W-1:0]    fu_indicator_byte;
   logic [hrp_pkg::FU_TYPE_W-1:0] fu_nal_type;
   logic                          fu_first;

   rtp_byte_type burst[$];
   rtp_byte_type expected_bytes[$];
   rtp_byte_type want_byte;

   logic sender_idle = 1'b1;
   logic receiver_idle = 1'b1;
   int   items_sent = 0;
   int   errors = 0;
   int   quiet_cycles = 0;

   always #4 clock = ~clock;

   function automatic int fragment_capacity();
      int cap;
      cap = int'(cfg_max_payload);
      if (cap < hrp_pkg::MIN_PAYLOAD) cap = hrp_pkg::MIN_PAYLOAD;
      if (cap > PAYLOAD_LIMIT) cap = PAYLOAD_LIMIT;
      return cap;
   endfunction

   function automatic void push_rtp_header();
      logic [31:0] word;
      word = {hrp_pkg::RTP_FIRST_BYTE, 1'b0, cfg_payload_type, rtp_seq};
      for (int i = 3; i >= 0; i--) burst.push_back('{word[8*i +: 8], 1'b0, 1'b0});
      for (int i = 3; i >= 0; i--) burst.push_back('{rtp_timestamp[8*i +: 8], 1'b0, 1'b0});
      for (int i = 3; i >= 0; i--) burst.push_back('{cfg_ssrc[8*i +: 8], 1'b0, 1'b0});
      rtp_seq = rtp_seq + 1'b1;
   endfunction

   function automatic void packetize_byte(input logic [hrp_pkg::DATA_W-1:0] b,
                                          input logic [hrp_pkg::LEN_W-1:0] len_in);
      int           cap;
      int           len;
      logic         nal_done;
      logic         frag_done;
      logic [7:0]   fu_header;
      rtp_byte_type tail;
      cap = fragment_capacity();
      len = int'(len_in);
      burst.delete();
      if (nal_left == 0) begin
         if (len == 0) len = 1;
         nal_left = hrp_pkg::LEN_W'(len - 1);
         frag_fill = '0;
         if (len < cap) begin
            in_fu_a = 1'b0;
            nal_done = (nal_left == 0);
            push_rtp_header();
            burst.push_back('{b, nal_done, 1'b0});
            if (nal_done) rtp_timestamp = rtp_timestamp + hrp_pkg::TS_W'(cfg_timestamp_step);
         end else begin
            in_fu_a = 1'b1;
            fu_indicator_byte = (b & hrp_pkg::NRI_MASK) | hrp_pkg::FU_A_TYPE;
            fu_nal_type = b[hrp_pkg::FU_TYPE_W-1:0];
            fu_first = 1'b1;
         end
      end else if (!in_fu_a) begin
         nal_left = nal_left - 1'b1;
         nal_done = (nal_left == 0);
         burst.push_back('{b, nal_done, 1'b0});
         if (nal_done) rtp_timestamp = rtp_timestamp + hrp_pkg::TS_W'(cfg_timestamp_step);
      end else begin
         if (frag_fill == 0) begin
            fu_header = {3'b000, fu_nal_type};
            if (fu_first) fu_header = fu_header | hrp_pkg::FU_START_BIT;
            if (nal_left <= cap) fu_header = fu_header | hrp_pkg::FU_END_BIT;
            fu_first = 1'b0;
            push_rtp_header();
            burst.push_back('{fu_indicator_byte, 1'b0, 1'b0});
            burst.push_back('{fu_header, 1'b0, 1'b0});
         end
         nal_left = nal_left - 1'b1;
         frag_fill = frag_fill + 1'b1;
         nal_done = (nal_left == 0);
         frag_done = nal_done || (frag_fill >= cap);
         burst.push_back('{b, frag_done, 1'b0});
         if (frag_done) frag_fill = '0;
         if (nal_done) begin
            in_fu_a = 1'b0;
            rtp_timestamp = rtp_timestamp + hrp_pkg::TS_W'(cfg_timestamp_step);
         end
      end
      if (burst.size() > 0) begin
         tail = burst.pop_back();
         tail.run_last = 1'b1;
         burst.push_back(tail);
      end
      foreach (burst[i]) expected_bytes.push_back(burst[i]);
   endfunction

   function automatic int draw_gap(input logic enabled);
      if (!enabled || $urandom_range(0, 1) == 0) return 0;
      return $urandom_range(1, 13);
   endfunction

   function automatic logic [hrp_pkg::CSR_DATA_W-1:0] random_max_payload();
      case ($urandom_range(0, 9))
         0: return $urandom_range(0, 1);
         1: return $urandom_range(1400, 2047);
         2: return $urandom;
         default: return $urandom_range(2, 12);
      endcase
   endfunction

   // All driving tasks start and end at a falling edge.
   task automatic send_byte(input logic [hrp_pkg::DATA_W-1:0] b,
                            input logic [hrp_pkg::LEN_W-1:0] len);
      int gap;
      gap = draw_gap(sender_idle);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.data_byte <= b;
      req_if.nal_length <= len;
      @(posedge clock);
      while (req_if.ready !== 1'b1) @(posedge clock);
      packetize_byte(b, len);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_if.valid <= 1'b0;
      while (expected_bytes.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [hrp_pkg::CSR_INDEX_W-1:0] index,
                            input logic [hrp_pkg::CSR_DATA_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_index <= index;
      csr_write_data <= value;
      case (index)
         hrp_pkg::REG_PAYLOAD_TYPE:   cfg_payload_type = value[hrp_pkg::PT_W-1:0];
         hrp_pkg::REG_SSRC:           cfg_ssrc = value[hrp_pkg::SSRC_W-1:0];
         hrp_pkg::REG_MAX_PAYLOAD:    cfg_max_payload = value[hrp_pkg::MAXPAY_W-1:0];
         hrp_pkg::REG_TIMESTAMP_STEP: cfg_timestamp_step = value[hrp_pkg::TSSTEP_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_write_enable <= 1'b0;
      @(negedge clock);
   endtask

   task automatic program_registers(input logic [hrp_pkg::CSR_DATA_W-1:0] payload_type,
                                    input logic [hrp_pkg::CSR_DATA_W-1:0] ssrc,
                                    input logic [hrp_pkg::CSR_DATA_W-1:0] max_payload,
                                    input logic [hrp_pkg::CSR_DATA_W-1:0] timestamp_step);
      wait_idle();
      write_reg(hrp_pkg::REG_PAYLOAD_TYPE, payload_type);
      write_reg(hrp_pkg::REG_SSRC, ssrc);
      write_reg(hrp_pkg::REG_MAX_PAYLOAD, max_payload);
      write_reg(hrp_pkg::REG_TIMESTAMP_STEP, timestamp_step);
   endtask

   task automatic send_nal(input int len, input logic [hrp_pkg::DATA_W-1:0] nal_header);
      send_byte(nal_header, len[hrp_pkg::LEN_W-1:0]);
      for (int i = 1; i < len; i++) begin
         send_byte(hrp_pkg::DATA_W'($urandom), hrp_pkg::LEN_W'($urandom));
      end
   endtask

   task automatic test_single_nal_packets();
      send_nal(1, 8'h00);
      send_nal(0, 8'hFF);
      send_nal(3, 8'h67);
   endtask

   task automatic test_fu_a_fragments();
      program_registers(32'd0, 32'hFFFF_FFFF, 32'd4, 32'd90000);
      send_nal(4, 8'h65);
      send_nal(3, 8'hFF);
      send_nal(10, 8'h00);
   endtask

   task automatic test_payload_clamp();
      program_registers(32'd35, 32'hA5A5_5A5A, 32'd1, 32'd0);
      send_nal(1, 8'h41);
      send_nal(2, 8'hE5);
      wait_idle();
      write_reg(hrp_pkg::REG_MAX_PAYLOAD, 32'd0);
      send_nal(5, 8'h1F);
   endtask

   task automatic test_mid_nal_reconfig();
      program_registers(hrp_pkg::CSR_DATA_W'(hrp_pkg::PAYLOAD_TYPE_RESET), 32'h1234_5678,
                        32'd4, 32'd1);
      send_byte(8'h5C, 16'd14);
      for (int i = 1; i < 14; i++) begin
         if (i == 6) begin
            wait_idle();
            write_reg(hrp_pkg::REG_MAX_PAYLOAD, 32'd8);
         end
         if (i == 10) begin
            wait_idle();
            write_reg(hrp_pkg::REG_MAX_PAYLOAD, 32'd2);
         end
         send_byte(hrp_pkg::DATA_W'($urandom), hrp_pkg::LEN_W'($urandom));
      end
   endtask

   task automatic test_unpaced_nal();
      sender_idle = 1'b0;
      receiver_idle = 1'b0;
      program_registers(32'd127, $urandom, 32'h7FF,
                        hrp_pkg::CSR_DATA_W'(hrp_pkg::TIMESTAMP_STEP_RESET));
      send_nal(UNPACED_NAL_LENGTH, 8'h7C);
   endtask

   task automatic test_random_traffic();
      int                         target;
      int                         len;
      int                         split;
      int                         cap;
      logic [hrp_pkg::DATA_W-1:0] nal_header;
      logic [hrp_pkg::DATA_W-1:0] b;
      logic [hrp_pkg::LEN_W-1:0]  len_field;
      target = items_sent + RANDOM_ITEMS;
      while (items_sent < target) begin
         if ($urandom_range(0, 5) == 0) begin
            sender_idle = $urandom_range(0, 3) != 0;
            receiver_idle = $urandom_range(0, 3) != 0;
            program_registers($urandom, $urandom, random_max_payload(), $urandom);
         end
         cap = fragment_capacity();
         if (cap > 20) begin
            len = $urandom_range(0, 40);
         end else begin
            case ($urandom_range(0, 3))
               0: len = $urandom_range(0, 3);
               1: len = $urandom_range(cap - 1, cap + 1);
               default: len = $urandom_range(cap, 3 * cap + 2);
            endcase
         end
         split = ($urandom_range(0, 7) == 0) ? $urandom_range(1, len) : -1;
         nal_header = hrp_pkg::DATA_W'($urandom);
         for (int i = 0; i < ((len == 0) ? 1 : len); i++) begin
            if (i == split) begin
               wait_idle();
               write_reg(hrp_pkg::REG_MAX_PAYLOAD, random_max_payload());
            end
            b = (i == 0) ? nal_header : hrp_pkg::DATA_W'($urandom);
            len_field = (i == 0) ? hrp_pkg::LEN_W'(len) : hrp_pkg::LEN_W'($urandom);
            send_byte(b, len_field);
         end
      end
   endtask

   initial begin
      int gap;
      rsp_if.ready = 1'b0;
      @(negedge clock);
      forever begin
         gap = draw_gap(receiver_idle);
         if (gap > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_if.ready <= 1'b1;
         @(posedge clock);
         while (!(rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)) @(posedge clock);
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         if (expected_bytes.size() == 0) begin
            $error("out_byte: no byte expected, got %02h", rsp_if.out_byte);
            errors++;
         end else begin
            want_byte = expected_bytes.pop_front();
            if (rsp_if.out_byte !== want_byte.out_byte) begin
               $error("out_byte: expected %02h, got %02h", want_byte.out_byte, rsp_if.out_byte);
               errors++;
            end
            if (rsp_if.packet_end !== want_byte.packet_end) begin
               $error("packet_end: expected %0b, got %0b", want_byte.packet_end,
                      rsp_if.packet_end);
               errors++;
            end
            if (rsp_if.run_last !== want_byte.run_last) begin
               $error("run_last: expected %0b, got %0b", want_byte.run_last, rsp_if.run_last);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
          (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      req_if.valid = 1'b0;
      req_if.data_byte = '0;
      req_if.nal_length = '0;
      cfg_payload_type = hrp_pkg::PAYLOAD_TYPE_RESET;
      cfg_ssrc = hrp_pkg::SSRC_RESET;
      cfg_max_payload = hrp_pkg::MAX_PAYLOAD_RESET;
      cfg_timestamp_step = hrp_pkg::TIMESTAMP_STEP_RESET;
      rtp_seq = '0;
      rtp_timestamp = '0;
      nal_left = '0;
      frag_fill = '0;
      in_fu_a = 1'b0;
      fu_indicator_byte = '0;
      fu_nal_type = '0;
      fu_first = 1'b0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_single_nal_packets();
      test_fu_a_fragments();
      test_payload_clamp();
      test_mid_nal_reconfig();
      test_unpaced_nal();
      test_random_traffic();

      wait_idle();
      if (errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

[sim.f]
rtl/hrp_pkg.sv
rtl/hrp_req_if.sv
rtl/hrp_rsp_if.sv
rtl/h264_rtp_packetizer_top.sv
rtl/hrp_checker.sv
dv/h264_rtp_packetizer_top_tb.sv
